// ===== sv/rcwq_pkg.sv =====
// Shared types and constants for the radio carrier wake qualifier.
package rcwq_pkg;

  localparam int FIELD_BITS   = 16;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_TICKS      = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CARRIER_THRESHOLD = 1'd1;

  localparam logic [FIELD_BITS-1:0] WINDOW_TICKS_RESET      = 16'd1000;
  localparam logic [FIELD_BITS-1:0] CARRIER_THRESHOLD_RESET = 16'd10;

  typedef enum logic [2:0] {
    PH_WAIT_LOW = 3'd0,
    PH_ASLEEP   = 3'd1,
    PH_WAKE     = 3'd2,
    PH_SAMPLE   = 3'd3,
    PH_RESET    = 3'd4
  } phase_t;

  typedef struct packed {
    logic radio_level;
    logic button_level;
  } sample_t;

  typedef struct packed {
    logic [2:0]            phase;
    logic                  reset_request;
    logic                  indicator_on;
    logic [FIELD_BITS-1:0] high_count;
  } result_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] window_ticks;
    logic [FIELD_BITS-1:0] carrier_threshold;
  } cfg_t;

endpackage

// ===== sv/rcwq_state.sv =====
// Qualifier state registers and the per-sample next-state logic.
module rcwq_state import rcwq_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  sample_t item,
  input  cfg_t    cfg,
  output result_t step_result
);

  localparam int CMP_BITS = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  phase_t                phase_reg, phase_next;
  logic [COUNT_BITS-1:0] ticks_left, ticks_left_next;
  logic [COUNT_BITS-1:0] high_samples, high_samples_next;
  logic                  prev_button;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg    <= PH_WAIT_LOW;
      ticks_left   <= '0;
      high_samples <= '0;
      prev_button  <= 1'b1;
    end else if (step) begin
      phase_reg    <= phase_next;
      ticks_left   <= ticks_left_next;
      high_samples <= high_samples_next;
      prev_button  <= item.button_level;
    end
  end

  always_comb begin
    phase_next        = phase_reg;
    ticks_left_next   = ticks_left;
    high_samples_next = high_samples;
    case (phase_reg)
      PH_WAIT_LOW: begin
        if (!item.radio_level) phase_next = PH_ASLEEP;
      end
      PH_ASLEEP: begin
        if (item.radio_level || (prev_button && !item.button_level)) phase_next = PH_WAKE;
      end
      PH_WAKE: begin
        if (!item.button_level) begin
          phase_next = PH_RESET;
        end else begin
          ticks_left_next   = COUNT_BITS'(cfg.window_ticks);
          high_samples_next = '0;
          phase_next        = PH_SAMPLE;
        end
      end
      PH_SAMPLE: begin
        if (ticks_left != '0) begin
          ticks_left_next = ticks_left - 1'b1;
          if (item.radio_level && high_samples != COUNT_MAX) begin
            high_samples_next = high_samples + 1'b1;
          end
        end
        if (ticks_left_next == '0) begin
          if (high_samples_next == '0) begin
            phase_next = PH_WAIT_LOW;
          end else if (CMP_BITS'(high_samples_next) < CMP_BITS'(cfg.carrier_threshold)) begin
            phase_next = PH_WAKE;
          end else begin
            phase_next = PH_RESET;
          end
        end
      end
      PH_RESET: begin
        phase_next = PH_RESET;
      end
      default: begin
        phase_next = PH_WAIT_LOW;
      end
    endcase
  end

  assign step_result.phase         = phase_next;
  assign step_result.reset_request = (phase_next == PH_RESET);
  assign step_result.indicator_on  = (phase_next == PH_SAMPLE);
  assign step_result.high_count    = FIELD_BITS'(high_samples_next);

endmodule

// ===== sv/radio_carrier_wake_qualifier.sv =====
// Top level of the radio carrier wake qualifier: ports, configuration and stages.
//
// Every transaction on the sample channel is one tick of the radio and button
// pins and produces exactly one transaction on the result channel, showing the
// phase, the latched reset request, the indicator and the high-sample count as
// they stand after that tick. A sample goes into an input register, the next
// state is formed from it by the combinational state logic and written to the
// result register whenever the pipeline advances; one sample can be taken every
// clock cycle while the result channel does not stall. While the
// result register holds a stalled result the input register can still take one
// more sample; once both are full the sample channel stalls in the same cycle as
// the result channel. The window length and the carrier
// threshold are written through the plain configuration port (index 0 and 1)
// and should only change while no transaction is in flight. COUNT_BITS sets the
// width of the tick and high-sample counters; the reported count is the low
// sixteen bits of the high-sample counter, which saturates at its maximum.
module radio_carrier_wake_qualifier import rcwq_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  sample_t                 sample,
  output logic                    result_valid,
  input  logic                    result_stall,
  output result_t                 result,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0]   cfg_data
);

  cfg_t    cfg;
  sample_t item;
  logic    item_valid;
  logic    advance;
  logic    step;
  result_t step_result;

  // Configuration registers, written directly with no handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ticks      <= WINDOW_TICKS_RESET;
      cfg.carrier_threshold <= CARRIER_THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_TICKS:      cfg.window_ticks      <= cfg_data;
        CFG_CARRIER_THRESHOLD: cfg.carrier_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the result register is empty or being taken.
  assign advance      = !result_valid || !result_stall;
  assign step         = item_valid && advance;
  // The input register only refuses a sample when it is full and cannot drain.
  assign sample_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!sample_stall) begin
      item_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      item <= sample;
    end
  end

  rcwq_state #(
    .COUNT_BITS (COUNT_BITS)
  ) u_state (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (item),
    .cfg         (cfg),
    .step_result (step_result)
  );

  // Result register: loads the freshly computed state on every step.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= step_result;
    end
  end

endmodule

// ===== test/rcwq_checker.sv =====
`timescale 1ns / 1ps
// Checker for the radio carrier wake qualifier: predicts each result and compares it.
module rcwq_checker import rcwq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  input  logic                    sample_stall,
  input  sample_t                 sample,
  input  logic                    result_valid,
  input  logic                    result_stall,
  input  result_t                 result,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0]   cfg_data,
  output int                      in_flight,
  output int                      fail_count
);

  localparam logic [FIELD_BITS-1:0] COUNT_TOP = '1;

  cfg_t                  cfg_shadow;
  phase_t                phase_now;
  logic [FIELD_BITS-1:0] ticks_left;
  logic [FIELD_BITS-1:0] high_seen;
  logic                  button_last;
  result_t               due_q[$];
  int                    fails_seen = 0;

  // One pin sample tick of the wake qualifier, returning the state after the tick.
  task automatic advance_tick(input sample_t s, output result_t r);
    case (phase_now)
      PH_WAIT_LOW: begin
        if (!s.radio_level) phase_now = PH_ASLEEP;
      end
      PH_ASLEEP: begin
        if (s.radio_level || (button_last && !s.button_level)) phase_now = PH_WAKE;
      end
      PH_WAKE: begin
        if (!s.button_level) begin
          phase_now = PH_RESET;
        end else begin
          ticks_left = cfg_shadow.window_ticks;
          high_seen  = '0;
          phase_now  = PH_SAMPLE;
        end
      end
      PH_SAMPLE: begin
        if (ticks_left != '0) begin
          ticks_left = ticks_left - 1'b1;
          if (s.radio_level && high_seen != COUNT_TOP) high_seen = high_seen + 1'b1;
        end
        if (ticks_left == '0) begin
          if (high_seen == '0) phase_now = PH_WAIT_LOW;
          else if (high_seen < cfg_shadow.carrier_threshold) phase_now = PH_WAKE;
          else phase_now = PH_RESET;
        end
      end
      PH_RESET: begin
      end
      default: begin
        phase_now = PH_WAIT_LOW;
      end
    endcase
    button_last     = s.button_level;
    r.phase         = phase_now;
    r.reset_request = (phase_now == PH_RESET);
    r.indicator_on  = (phase_now == PH_SAMPLE);
    r.high_count    = high_seen;
  endtask

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t fresh;
    if (rst) begin
      cfg_shadow.window_ticks      = WINDOW_TICKS_RESET;
      cfg_shadow.carrier_threshold = CARRIER_THRESHOLD_RESET;
      phase_now   = PH_WAIT_LOW;
      ticks_left  = '0;
      high_seen   = '0;
      button_last = 1'b1;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_TICKS:      cfg_shadow.window_ticks = cfg_data;
          CFG_CARRIER_THRESHOLD: cfg_shadow.carrier_threshold = cfg_data;
          default: begin
          end
        endcase
      end
      if (result_valid && !result_stall) begin
        if (due_q.size() == 0) begin
          $error("result transaction with nothing expected: phase %0d, high_count %0d",
                 result.phase, result.high_count);
          fails_seen++;
        end else begin
          want = due_q.pop_front();
          fails_seen += field_differs("phase", 32'(want.phase), 32'(result.phase));
          fails_seen += field_differs("reset_request", 32'(want.reset_request),
                                      32'(result.reset_request));
          fails_seen += field_differs("indicator_on", 32'(want.indicator_on),
                                      32'(result.indicator_on));
          fails_seen += field_differs("high_count", 32'(want.high_count),
                                      32'(result.high_count));
        end
      end
      if (sample_valid && !sample_stall) begin
        advance_tick(sample, fresh);
        due_q.push_back(fresh);
      end
    end
    in_flight  <= due_q.size();
    fail_count <= fails_seen;
  end

endmodule

// ===== test/tb_radio_carrier_wake_qualifier.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the radio carrier wake qualifier, with the checker beside the block.
module tb_radio_carrier_wake_qualifier;
  import rcwq_pkg::*;

  // Directed opening: holds the button low through the wait and asleep phases to show
  // that only a falling edge wakes, wakes on the button, runs a window with a partial
  // count that repeats the check, an empty window that goes back to waiting, and a
  // radio wake with a full window of highs. Window 4 and threshold 5 are in force.
  localparam logic [0:23] DIR_RADIO  = 24'b110000010110000001111110;
  localparam logic [0:23] DIR_BUTTON = 24'b100010111111111111111111;

  logic                    clk;
  logic                    rst;
  logic                    sample_valid;
  logic                    sample_stall;
  sample_t                 sample;
  logic                    result_valid;
  logic                    result_stall;
  result_t                 result;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [FIELD_BITS-1:0]   cfg_data;

  int pending;
  int fails;

  // Percent of cycles in which the sender holds back and the receiver stalls.
  int send_idle;
  int recv_idle;
  // Asks the receiver process for one long hold-off.
  bit hold_req;

  // Consecutive accepted ticks with the radio low and the button released. A button
  // press is only offered once this run exceeds the current window by two ticks: by
  // then no wake check can be due, so the press can only wake the block from sleep and
  // never latch the reset request early. The reset request latches for the rest of the
  // run, so it is reached once, on purpose, at the very end.
  int quiet_run;
  int cur_window;
  int radio_pct;
  int burst_left;

  radio_carrier_wake_qualifier u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  rcwq_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_flight    (pending),
    .fail_count   (fails)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run ends here if the block stops moving transactions.
  initial begin
    #10_000_000;
    $display("tb_radio_carrier_wake_qualifier: errors");
    $finish;
  end

  // Receiver: random stalls at the current rate, or a long hold-off when asked for one,
  // so the block fills up and has to stall its sample channel.
  initial begin : receiver
    int hold_left;
    hold_left    = 0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // Offers one sample tick, with random gaps first, and returns at the edge that
  // accepts it. Valid stays high from one transaction to the next unless a gap falls.
  task automatic put_sample(input logic radio, input logic button);
    while ($urandom_range(99) < send_idle) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= '{radio_level: radio, button_level: button};
    do @(posedge clk); while (sample_stall);
    if (!radio && button) quiet_run++;
    else quiet_run = 0;
  endtask

  // Random ticks in bursts of a fixed radio activity level, from silence to a steady
  // carrier, so that windows end empty, partly filled or full.
  task automatic random_ticks(input int count);
    logic radio;
    logic button;
    int   span;
    repeat (count) begin
      if (burst_left == 0) begin
        case ($urandom_range(4))
          0:       radio_pct = 0;
          1:       radio_pct = 5;
          2:       radio_pct = 50;
          3:       radio_pct = 95;
          default: radio_pct = 100;
        endcase
        span       = 2 * ((cur_window < 100) ? cur_window : 100) + 20;
        burst_left = $urandom_range(span, 1);
      end
      burst_left--;
      radio  = ($urandom_range(99) < radio_pct);
      button = !(quiet_run >= cur_window + 2 && $urandom_range(99) < 25);
      put_sample(radio, button);
    end
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers on back-to-back edges; the block must be idle.
  task automatic program_block(input logic [FIELD_BITS-1:0] window,
                               input logic [FIELD_BITS-1:0] threshold);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_TICKS;
    cfg_data  <= window;
    @(posedge clk);
    cfg_index <= CFG_CARRIER_THRESHOLD;
    cfg_data  <= threshold;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_window = int'(window);
  endtask

  // Quiet ticks long enough to finish any window in flight, a repeated check included, so the
  // block is asleep with nothing pending when the new setting goes in. Every setting but the
  // last sets a threshold above the window or a zero window, so none can reach the reset state.
  task automatic settle_and_program(input logic [FIELD_BITS-1:0] window,
                                    input logic [FIELD_BITS-1:0] threshold);
    repeat (2 * cur_window + 4) put_sample(1'b0, 1'b1);
    wait_drained();
    program_block(window, threshold);
  endtask

  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    hold_req     = 1'b0;
    quiet_run    = 0;
    cur_window   = WINDOW_TICKS_RESET;
    radio_pct    = 0;
    burst_left   = 0;
    send_idle    = 18;
    recv_idle    = 71;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The reset default threshold lies below the window, so a short safe setting goes in
    // before the first tick.
    program_block(16'd4, 16'd5);
    for (int i = 0; i < 24; i++) put_sample(DIR_RADIO[i], DIR_BUTTON[i]);
    random_ticks(40);

    // Sender mostly busy, receiver mostly stalled. The zero window decides on its first
    // sampling tick with nothing counted; the zero threshold rides along with it.
    settle_and_program(16'd6, 16'd9);
    random_ticks(150);
    settle_and_program(16'd0, 16'd0);
    random_ticks(60);

    // Sender mostly idle, receiver mostly ready, one long hold-off.
    send_idle = 71;
    recv_idle = 18;
    settle_and_program(16'd1, 16'd2);
    random_ticks(100);
    settle_and_program(16'd40, 16'hFFFF);
    hold_req = 1'b1;
    random_ticks(120);
    settle_and_program(16'd0, 16'd1);
    random_ticks(30);

    // No idling on either side; another hold-off fills the block at full rate.
    send_idle = 0;
    recv_idle = 0;
    settle_and_program(16'd100, 16'd101);
    hold_req = 1'b1;
    random_ticks(80);
    settle_and_program(16'd13, 16'd20);
    random_ticks(60);

    // Window and threshold of 150: a radio wake, then a full window of highs counts up
    // to the threshold and latches the reset request. Random ticks afterwards must leave
    // it latched.
    settle_and_program(16'd150, 16'd150);
    repeat (152) put_sample(1'b1, 1'b1);
    repeat (30) put_sample(1'($urandom_range(1)), 1'($urandom_range(1)));

    wait_drained();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("tb_radio_carrier_wake_qualifier: clean");
    end else begin
      $display("tb_radio_carrier_wake_qualifier: errors");
    end
    $finish;
  end

endmodule
